/* sv/rsi_pkg.sv */
// shared types, constants and helpers for the ray/sphere intersection block
package rsi_pkg;

  localparam logic [30:0] T_MAX      = 31'h7FFF_FFFF;
  localparam logic [30:0] RADIUS_RST = 31'd65536;
  localparam logic [61:0] RR_RST     = 62'(RADIUS_RST) * 62'(RADIUS_RST);

  typedef enum logic [1:0] {
    REG_CENTER_X = 2'd0,
    REG_CENTER_Y = 2'd1,
    REG_CENTER_Z = 2'd2,
    REG_RADIUS   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        best_so_far;
  } ray_t;

  typedef struct packed {
    logic               hit;
    logic [30:0]        hit_distance;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } res_t;

  // sphere setup seen by the datapath
  typedef struct packed {
    logic [2:0][31:0] center;
    logic [61:0]      rr;
  } cfg_t;

  // what travels beside the discriminant through the first square root
  typedef struct packed {
    ray_t        ray;
    logic [63:0] a;
    logic [63:0] bmag;
    logic        b_neg;
    logic        miss;
  } front_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/rsi_if.sv */
// request channels: ray in, intersection result out
interface rsi_ray_if;
  import rsi_pkg::*;
  logic valid;
  logic ready;
  ray_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rsi_hit_if;
  import rsi_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* sv/rsi_sqrt_pipe.sv */
// pipelined integer square root, one result bit per stage
module rsi_sqrt_pipe #(
  parameter int  IN_W  = 128,
  parameter type pay_t = logic
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  input  pay_t              pay_i,
  output logic              valid_o,
  output logic [IN_W/2-1:0] root_o,
  output pay_t              pay_o
);

  localparam int K = IN_W / 2;

  typedef struct packed {
    logic [IN_W-1:0] x;
    logic [K+1:0]    rem;
    logic [K-1:0]    root;
    pay_t            pay;
  } sq_t;

  logic [K-1:0] vld_q;
  sq_t          dat_q [K];

  for (genvar k = 0; k < K; k++) begin : g_st
    sq_t          cur;
    sq_t          nxt;
    logic [K+1:0] sh;
    logic [K+1:0] trial;

    if (k == 0) begin : g_first
      always_comb begin
        cur.x    = rad_i;
        cur.rem  = '0;
        cur.root = '0;
        cur.pay  = pay_i;
      end
    end else begin : g_next
      assign cur = dat_q[k-1];
    end

    always_comb begin
      nxt   = cur;
      sh    = {cur.rem[K-1:0], cur.x[IN_W-1 -: 2]};
      trial = {cur.root, 2'b01};
      nxt.x = {cur.x[IN_W-3:0], 2'b00};
      if (sh >= trial) begin
        nxt.rem  = sh - trial;
        nxt.root = {cur.root[K-2:0], 1'b1};
      end else begin
        nxt.rem  = sh;
        nxt.root = {cur.root[K-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= (k == 0) ? valid_i : vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dat_q[k] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[K-1];
  assign root_o  = dat_q[K-1].root;
  assign pay_o   = dat_q[K-1].pay;

endmodule

/* sv/rsi_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage
module rsi_div_pipe #(
  parameter int  NUM_W = 81,
  parameter int  DEN_W = 64,
  parameter int  Q_W   = 31,
  parameter type pay_t = logic
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  pay_t             pay_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output pay_t             pay_o
);

  // caller keeps the dividend below den << Q_W
  localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  typedef struct packed {
    logic [W-1:0]     rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
    pay_t             pay;
  } dv_t;

  logic [Q_W-1:0] vld_q;
  dv_t            dat_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_st
    localparam int BIT = Q_W - 1 - k;
    dv_t          cur;
    dv_t          nxt;
    logic [W-1:0] trial;

    if (k == 0) begin : g_first
      always_comb begin
        cur.rem = W'(num_i);
        cur.den = den_i;
        cur.quo = '0;
        cur.pay = pay_i;
      end
    end else begin : g_next
      assign cur = dat_q[k-1];
    end

    always_comb begin
      nxt   = cur;
      trial = W'(cur.den) << BIT;
      if (cur.rem >= trial) begin
        nxt.rem      = cur.rem - trial;
        nxt.quo[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= (k == 0) ? valid_i : vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dat_q[k] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = dat_q[Q_W-1].quo;
  assign pay_o   = dat_q[Q_W-1].pay;

endmodule

/* sv/rsi_front.sv */
// quadratic setup: offset, dot products, coefficients and discriminant
module rsi_front
  import rsi_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  ray_t         ray_i,
  input  cfg_t         cfg_i,
  output logic         valid_o,
  output logic [127:0] disc_o,
  output front_t       pay_o
);

  typedef struct packed {
    ray_t             ray;
    logic [2:0][31:0] oc;
  } s1_t;

  typedef struct packed {
    ray_t             ray;
    logic [2:0][63:0] dd;
    logic [2:0][63:0] od;
    logic [2:0][63:0] oo;
  } s2_t;

  typedef struct packed {
    ray_t        ray;
    logic [63:0] a;
    logic [65:0] b;
    logic [65:0] c;
  } s3_t;

  typedef struct packed {
    front_t      f;
    logic [63:0] cmag;
    logic        c_neg;
  } s4_t;

  typedef struct packed {
    front_t      f;
    logic        c_neg;
    logic [63:0] bhh;
    logic [63:0] bhl;
    logic [63:0] bll;
    logic [63:0] ahh;
    logic [63:0] ahl;
    logic [63:0] alh;
    logic [63:0] all;
  } s5_t;

  typedef struct packed {
    front_t       f;
    logic         c_neg;
    logic [127:0] bb;
    logic [127:0] ac;
  } s6_t;

  typedef struct packed {
    front_t       f;
    logic [127:0] disc;
  } s7_t;

  logic [6:0] vld_q;
  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;
  s7_t s7_d, s7_q;

  logic [2:0][31:0] org;
  logic [2:0][31:0] dir;
  logic [2:0][31:0] d1;

  assign org = {ray_i.origin_z, ray_i.origin_y, ray_i.origin_x};
  assign dir = {s1_q.ray.dir_z, s1_q.ray.dir_y, s1_q.ray.dir_x};
  assign d1  = dir;

  // offset from center
  always_comb begin
    s1_d.ray = ray_i;
    for (int i = 0; i < 3; i++) begin
      s1_d.oc[i] = sat32(66'($signed(org[i])) - 66'($signed(cfg_i.center[i])));
    end
  end

  // per-axis products
  always_comb begin
    s2_d.ray = s1_q.ray;
    for (int i = 0; i < 3; i++) begin
      s2_d.dd[i] = 64'($signed(d1[i]) * $signed(d1[i]));
      s2_d.od[i] = 64'($signed(s1_q.oc[i]) * $signed(d1[i]));
      s2_d.oo[i] = 64'($signed(s1_q.oc[i]) * $signed(s1_q.oc[i]));
    end
  end

  // coefficients a, half b, c
  always_comb begin
    s3_d.ray = s2_q.ray;
    s3_d.a   = s2_q.dd[0] + s2_q.dd[1] + s2_q.dd[2];
    s3_d.b   = 66'($signed(s2_q.od[0])) + 66'($signed(s2_q.od[1]))
             + 66'($signed(s2_q.od[2]));
    s3_d.c   = 66'(s2_q.oo[0]) + 66'(s2_q.oo[1]) + 66'(s2_q.oo[2]) - 66'(cfg_i.rr);
  end

  always_comb begin
    logic [65:0] nb;
    logic [65:0] nc;
    nb           = 66'(0) - s3_q.b;
    nc           = 66'(0) - s3_q.c;
    s4_d.f.ray   = s3_q.ray;
    s4_d.f.a     = s3_q.a;
    s4_d.f.b_neg = s3_q.b[65];
    s4_d.f.bmag  = s3_q.b[65] ? nb[63:0] : s3_q.b[63:0];
    s4_d.f.miss  = (s3_q.a == 64'd0);
    s4_d.c_neg   = s3_q.c[65];
    s4_d.cmag    = s3_q.c[65] ? nc[63:0] : s3_q.c[63:0];
  end

  // 64x64 products split into 32x32 partials
  always_comb begin
    s5_d.f     = s4_q.f;
    s5_d.c_neg = s4_q.c_neg;
    s5_d.bhh   = s4_q.f.bmag[63:32] * s4_q.f.bmag[63:32];
    s5_d.bhl   = s4_q.f.bmag[63:32] * s4_q.f.bmag[31:0];
    s5_d.bll   = s4_q.f.bmag[31:0]  * s4_q.f.bmag[31:0];
    s5_d.ahh   = s4_q.f.a[63:32] * s4_q.cmag[63:32];
    s5_d.ahl   = s4_q.f.a[63:32] * s4_q.cmag[31:0];
    s5_d.alh   = s4_q.f.a[31:0]  * s4_q.cmag[63:32];
    s5_d.all   = s4_q.f.a[31:0]  * s4_q.cmag[31:0];
  end

  always_comb begin
    s6_d.f     = s5_q.f;
    s6_d.c_neg = s5_q.c_neg;
    s6_d.bb    = {s5_q.bhh, 64'd0} + (128'(s5_q.bhl) << 33) + 128'(s5_q.bll);
    s6_d.ac    = {s5_q.ahh, 64'd0} + (128'(s5_q.ahl) << 32) + (128'(s5_q.alh) << 32)
               + 128'(s5_q.all);
  end

  // negative discriminant is a miss
  always_comb begin
    s7_d.f = s6_q.f;
    if (s6_q.c_neg) begin
      s7_d.disc = s6_q.bb + s6_q.ac;
    end else begin
      s7_d.disc = s6_q.bb - s6_q.ac;
      if (s6_q.bb < s6_q.ac) begin
        s7_d.f.miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
      s6_q <= s6_d;
      s7_q <= s7_d;
    end
  end

  assign valid_o = vld_q[6];
  assign disc_o  = s7_q.disc;
  assign pay_o   = s7_q.f;

endmodule

/* sv/ray_sphere_intersect.sv */
// Ray/sphere intersection, fully pipelined: one ray request is taken per clock
// while the output side does not stall, and each gives exactly one result
// request, in order. The pipeline is built from the bit-per-stage units:
// a 64-stage square root of the discriminant, a 31-stage divider for the hit
// distance, a 33-stage square root of the normal length and three 16-stage
// normal dividers, plus 16 arithmetic stages. A stall at the output freezes the
// whole pipeline. The sphere registers may be written only while no request is
// in flight.
module ray_sphere_intersect
  import rsi_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsi_ray_if.sink     ray_i,
  rsi_hit_if.source   hit_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int NUM_W = 65 + FRAC_BITS;
  localparam int CMP_W = 96 + FRAC_BITS;

  typedef struct packed {
    ray_t ray;
    logic miss;
  } dpay_t;

  typedef struct packed {
    ray_t        ray;
    logic [63:0] a;
    logic [64:0] num;
    logic        miss;
  } t1_t;

  typedef struct packed {
    dpay_t            p;
    logic [63:0]      a;
    logic [NUM_W-1:0] dvd;
  } t2_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      t;
    logic [2:0][31:0] org;
    logic [2:0][63:0] prod;
  } h1_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      t;
    logic [2:0][31:0] pt;
  } h2_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      t;
    logic [2:0][31:0] pt;
    logic [2:0][32:0] n;
  } h3_t;

  typedef struct packed {
    h3_t              h;
    logic [2:0][64:0] sq;
  } h4_t;

  typedef struct packed {
    logic             hit;
    logic [30:0]      t;
    logic [2:0][31:0] pt;
    logic             lzero;
    logic             neg0;
  } npay_t;

  typedef struct packed {
    npay_t            p;
    logic             neg1;
    logic             neg2;
    logic [2:0][47:0] dvd;
    logic [32:0]      len;
  } n1_t;

  // configuration
  logic signed [31:0] center_x_q, center_y_q, center_z_q;
  logic [30:0]        radius_q;
  logic [61:0]        rr_q;
  cfg_t               cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      radius_q   <= RADIUS_RST;
      rr_q       <= RR_RST;
    end else begin
      rr_q <= 62'(radius_q) * 62'(radius_q);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_CENTER_X: center_x_q <= cfg_data_i;
          REG_CENTER_Y: center_y_q <= cfg_data_i;
          REG_CENTER_Z: center_z_q <= cfg_data_i;
          REG_RADIUS:   radius_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg.center = {center_z_q, center_y_q, center_x_q};
  assign cfg.rr     = rr_q;

  // global advance: whole pipeline moves when the output slot frees
  logic en;
  logic out_vld_q;
  res_t out_q;

  assign en          = !out_vld_q || hit_o.ready;
  assign ray_i.ready = en;

  // quadratic setup and first root
  logic         fr_vld;
  logic [127:0] fr_disc;
  front_t       fr_pay;

  rsi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ray_i.valid),
    .ray_i   (ray_i.data),
    .cfg_i   (cfg),
    .valid_o (fr_vld),
    .disc_o  (fr_disc),
    .pay_o   (fr_pay)
  );

  logic        sq1_vld;
  logic [63:0] sq1_root;
  front_t      sq1_pay;

  rsi_sqrt_pipe #(.IN_W(128), .pay_t(front_t)) u_sqrt_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .rad_i   (fr_disc),
    .pay_i   (fr_pay),
    .valid_o (sq1_vld),
    .root_o  (sq1_root),
    .pay_o   (sq1_pay)
  );

  // smaller non-negative root numerator
  logic [1:0] tv_q;
  t1_t t1_d, t1_q;
  t2_t t2_d, t2_q;

  always_comb begin
    logic near;
    near      = sq1_pay.b_neg || (sq1_pay.bmag == 64'd0);
    t1_d.ray  = sq1_pay.ray;
    t1_d.a    = sq1_pay.a;
    t1_d.miss = sq1_pay.miss;
    if (near && (sq1_pay.bmag >= sq1_root)) begin
      t1_d.num = 65'(sq1_pay.bmag - sq1_root);
    end else if (near) begin
      t1_d.num = 65'(sq1_pay.bmag) + 65'(sq1_root);
    end else if (sq1_root >= sq1_pay.bmag) begin
      t1_d.num = 65'(sq1_root - sq1_pay.bmag);
    end else begin
      t1_d.num  = '0;
      t1_d.miss = 1'b1;
    end
  end

  // quotient that would not fit in 31 bits can never beat the best distance
  always_comb begin
    t2_d.p.ray  = t1_q.ray;
    t2_d.a      = t1_q.a;
    t2_d.dvd    = {t1_q.num, {FRAC_BITS{1'b0}}};
    t2_d.p.miss = t1_q.miss
                || (CMP_W'({t1_q.num, {FRAC_BITS{1'b0}}}) >= CMP_W'({t1_q.a, 31'd0}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= '0;
    end else if (en) begin
      tv_q <= {tv_q[0], sq1_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= t1_d;
      t2_q <= t2_d;
    end
  end

  logic        dt_vld;
  logic [30:0] dt_quo;
  dpay_t       dt_pay;

  rsi_div_pipe #(.NUM_W(NUM_W), .DEN_W(64), .Q_W(31), .pay_t(dpay_t)) u_div_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (tv_q[1]),
    .num_i   (t2_q.dvd),
    .den_i   (t2_q.a),
    .pay_i   (t2_q.p),
    .valid_o (dt_vld),
    .quo_o   (dt_quo),
    .pay_o   (dt_pay)
  );

  // hit point and normal vector
  logic [4:0] hv_q;
  h1_t h1_d, h1_q;
  h2_t h2_d, h2_q;
  h3_t h3_d, h3_q;
  h4_t h4_d, h4_q;
  npay_t h5_d, h5_q;
  logic [65:0] nn_d, nn_q;
  logic [2:0][31:0] dt_dir;

  assign dt_dir = {dt_pay.ray.dir_z, dt_pay.ray.dir_y, dt_pay.ray.dir_x};

  always_comb begin
    h1_d.hit = !dt_pay.miss && (dt_quo < dt_pay.ray.best_so_far);
    h1_d.t   = dt_quo;
    h1_d.org = {dt_pay.ray.origin_z, dt_pay.ray.origin_y, dt_pay.ray.origin_x};
    for (int i = 0; i < 3; i++) begin
      h1_d.prod[i] = 64'($signed({1'b0, dt_quo}) * $signed(dt_dir[i]));
    end
  end

  always_comb begin
    h2_d.hit = h1_q.hit;
    h2_d.t   = h1_q.t;
    for (int i = 0; i < 3; i++) begin
      h2_d.pt[i] = sat32(66'($signed(h1_q.org[i]))
                       + 66'($signed(h1_q.prod[i]) >>> FRAC_BITS));
    end
  end

  always_comb begin
    h3_d.hit = h2_q.hit;
    h3_d.t   = h2_q.t;
    h3_d.pt  = h2_q.pt;
    for (int i = 0; i < 3; i++) begin
      h3_d.n[i] = 33'($signed(h2_q.pt[i])) - 33'($signed(cfg.center[i]));
    end
  end

  always_comb begin
    h4_d.h = h3_q;
    for (int i = 0; i < 3; i++) begin
      h4_d.sq[i] = 65'($signed(h3_q.n[i]) * $signed(h3_q.n[i]));
    end
  end

  always_comb begin
    h5_d.hit   = h4_q.h.hit;
    h5_d.t     = h4_q.h.t;
    h5_d.pt    = h4_q.h.pt;
    h5_d.lzero = 1'b0;
    h5_d.neg0  = 1'b0;
    nn_d       = 66'(h4_q.sq[0]) + 66'(h4_q.sq[1]) + 66'(h4_q.sq[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q <= '0;
    end else if (en) begin
      hv_q <= {hv_q[3:0], dt_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h1_q <= h1_d;
      h2_q <= h2_d;
      h3_q <= h3_d;
      h4_q <= h4_d;
      h5_q <= h5_d;
      nn_q <= nn_d;
    end
  end

  // normal components and center offset ride along the length root
  typedef struct packed {
    npay_t            p;
    logic [2:0][32:0] n;
  } lpay_t;

  lpay_t       sq2_in;
  logic        sq2_vld;
  logic [32:0] sq2_root;
  lpay_t       sq2_pay;
  logic [2:0][32:0] n_pipe_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_pipe_q[0] <= h3_q.n;
      n_pipe_q[1] <= n_pipe_q[0];
    end
  end

  assign sq2_in.p = h5_q;
  assign sq2_in.n = n_pipe_q[1];

  rsi_sqrt_pipe #(.IN_W(66), .pay_t(lpay_t)) u_sqrt_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (hv_q[4]),
    .rad_i   (nn_q),
    .pay_i   (sq2_in),
    .valid_o (sq2_vld),
    .root_o  (sq2_root),
    .pay_o   (sq2_pay)
  );

  logic n1_vld_q;
  n1_t  n1_d, n1_q;
  logic [2:0] nsign;

  always_comb begin
    logic [32:0] m;
    n1_d.p       = sq2_pay.p;
    n1_d.p.lzero = (sq2_root == 33'd0);
    n1_d.len     = sq2_root;
    for (int i = 0; i < 3; i++) begin
      nsign[i] = sq2_pay.n[i][32];
      m        = nsign[i] ? (33'd0 - sq2_pay.n[i]) : sq2_pay.n[i];
      n1_d.dvd[i] = {m, 15'd0};
    end
    n1_d.p.neg0 = nsign[0];
    n1_d.neg1   = nsign[1];
    n1_d.neg2   = nsign[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_vld_q <= 1'b0;
    end else if (en) begin
      n1_vld_q <= sq2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q <= n1_d;
    end
  end

  logic        dn0_vld, dn1_vld, dn2_vld;
  logic [15:0] dn0_quo, dn1_quo, dn2_quo;
  npay_t       dn0_pay;
  logic        dn1_neg, dn2_neg;

  rsi_div_pipe #(.NUM_W(48), .DEN_W(33), .Q_W(16), .pay_t(npay_t)) u_div_nx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n1_vld_q),
    .num_i   (n1_q.dvd[0]),
    .den_i   (n1_q.len),
    .pay_i   (n1_q.p),
    .valid_o (dn0_vld),
    .quo_o   (dn0_quo),
    .pay_o   (dn0_pay)
  );

  rsi_div_pipe #(.NUM_W(48), .DEN_W(33), .Q_W(16), .pay_t(logic)) u_div_ny (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n1_vld_q),
    .num_i   (n1_q.dvd[1]),
    .den_i   (n1_q.len),
    .pay_i   (n1_q.neg1),
    .valid_o (dn1_vld),
    .quo_o   (dn1_quo),
    .pay_o   (dn1_neg)
  );

  rsi_div_pipe #(.NUM_W(48), .DEN_W(33), .Q_W(16), .pay_t(logic)) u_div_nz (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n1_vld_q),
    .num_i   (n1_q.dvd[2]),
    .den_i   (n1_q.len),
    .pay_i   (n1_q.neg2),
    .valid_o (dn2_vld),
    .quo_o   (dn2_quo),
    .pay_o   (dn2_neg)
  );

  // apply sign, clamp +1.0 to the largest Q1.15 value
  function automatic logic [15:0] norm_q15(input logic [15:0] q, input logic neg);
    logic [15:0] r;
    if (neg) begin
      r = 16'd0 - q;
    end else if (q[15]) begin
      r = 16'h7FFF;
    end else begin
      r = q;
    end
    return r;
  endfunction

  res_t out_d;

  always_comb begin
    out_d = '0;
    if (dn0_pay.hit) begin
      out_d.hit          = 1'b1;
      out_d.hit_distance = dn0_pay.t;
      out_d.point_x      = dn0_pay.pt[0];
      out_d.point_y      = dn0_pay.pt[1];
      out_d.point_z      = dn0_pay.pt[2];
      if (!dn0_pay.lzero) begin
        out_d.normal_x = norm_q15(dn0_quo, dn0_pay.neg0);
        out_d.normal_y = norm_q15(dn1_quo, dn1_neg);
        out_d.normal_z = norm_q15(dn2_quo, dn2_neg);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dn0_vld && dn1_vld && dn2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign hit_o.valid = out_vld_q;
  assign hit_o.data  = out_q;

endmodule
